// ===== rtl/two_sat_scc_solver_core_macros.svh =====
// ----------------------------------------------------------------------------
// 2-SAT SCC solver assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_SAT_SCC_SOLVER_CORE_MACROS_SVH
`define TWO_SAT_SCC_SOLVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TSS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define TSS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TSS_ASSERT(lbl, cond, msg)
`define TSS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// 2-SAT SCC solver package
// Sizes, opcodes, controller/datapath records and helper functions.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int MAX_VARS = 32;
    localparam int LIT_NUM  = 2 * MAX_VARS;
    localparam int LIT_W    = $clog2(LIT_NUM);
    localparam int CNT_W    = LIT_W + 1;
    localparam int VAR_W    = $clog2(MAX_VARS);
    localparam int NV_W     = 6;

    localparam logic [1:0] ST_COUNT = 2'd0;
    localparam logic [1:0] ST_TRUE  = 2'd1;
    localparam logic [1:0] ST_UNSAT = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_E_RD1, S_E_WR1, S_E_RD2, S_E_WR2,
        S_P1_INIT, S_P1_SCAN, S_P1_RD, S_P1_EVAL, S_P1_POP,
        S_P2_INIT, S_P2_FRD, S_P2_ROOT, S_P2_RD, S_P2_EVAL, S_P2_POP,
        S_C_INIT, S_C_RD, S_C_EVAL, S_O_RD, S_O_EVAL,
        S_CLR_INIT, S_CLR
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE, OP_E_RD1, OP_E_WR1, OP_E_RD2, OP_E_WR2,
        OP_P1_INIT, OP_P1_SCAN, OP_P1_RD, OP_P1_EVAL, OP_P1_POP,
        OP_P2_INIT, OP_P2_FRD, OP_P2_ROOT, OP_P2_RD, OP_P2_EVAL, OP_P2_POP,
        OP_C_INIT, OP_C_RD, OP_C_EVAL, OP_O_RD, OP_O_EVAL,
        OP_CLR_INIT, OP_CLR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_cmd;

    typedef struct packed {
        logic in_edge;
        logic in_last;
        logic last_item;
        logic scan_end;
        logic vis_hit;
        logic m_nz;
        logic sp_one;
        logic k_zero;
        logic root_done;
        logic eq;
        logic gt;
        logic var_last;
        logic cnt_zero;
        logic rem_one;
        logic clr_end;
    } t_stat;

    function automatic logic [LIT_W-1:0] low_bit(input logic [LIT_NUM-1:0] m);
        logic [LIT_W-1:0] r;
        r = LIT_W'(LIT_NUM - 1);
        for (int j = LIT_NUM - 1; j >= 0; j--) begin
            if (m[j]) begin
                r = LIT_W'(j);
            end
        end
        return r;
    endfunction

    function automatic logic [NV_W-1:0] eff_vars(input logic [NV_W-1:0] nv);
        logic [NV_W-1:0] r;
        r = nv;
        if (nv == '0) begin
            r = NV_W'(1);
        end else if (nv > NV_W'(MAX_VARS)) begin
            r = NV_W'(MAX_VARS);
        end
        return r;
    endfunction

endpackage

// ===== rtl/tss_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// 2-SAT SCC solver controller
// Sequences loading, both search passes, result output and matrix clearing.
// ----------------------------------------------------------------------------
module tss_ctrl
    import tss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_stat.in_edge) n_state = S_E_RD1;
                    else if (i_stat.in_last) n_state = S_P1_INIT;
                end
            end
            S_E_RD1: n_state = S_E_WR1;
            S_E_WR1: n_state = S_E_RD2;
            S_E_RD2: n_state = S_E_WR2;
            S_E_WR2: n_state = i_stat.last_item ? S_P1_INIT : S_IDLE;
            S_P1_INIT: n_state = S_P1_SCAN;
            S_P1_SCAN: begin
                if (i_stat.scan_end) n_state = S_P2_INIT;
                else if (!i_stat.vis_hit) n_state = S_P1_RD;
            end
            S_P1_RD: n_state = S_P1_EVAL;
            S_P1_EVAL: begin
                if (i_stat.m_nz) n_state = S_P1_RD;
                else if (i_stat.sp_one) n_state = S_P1_SCAN;
                else n_state = S_P1_POP;
            end
            S_P1_POP: n_state = S_P1_RD;
            S_P2_INIT: n_state = S_P2_FRD;
            S_P2_FRD: n_state = i_stat.k_zero ? S_C_INIT : S_P2_ROOT;
            S_P2_ROOT: n_state = i_stat.root_done ? S_P2_FRD : S_P2_RD;
            S_P2_RD: n_state = S_P2_EVAL;
            S_P2_EVAL: begin
                if (i_stat.m_nz) n_state = S_P2_RD;
                else if (i_stat.sp_one) n_state = S_P2_FRD;
                else n_state = S_P2_POP;
            end
            S_P2_POP: n_state = S_P2_RD;
            S_C_INIT: n_state = S_C_RD;
            S_C_RD: n_state = S_C_EVAL;
            S_C_EVAL: begin
                if (i_stat.eq) n_state = S_CLR_INIT;
                else if (i_stat.var_last) n_state = i_stat.cnt_zero ? S_CLR_INIT : S_O_RD;
                else n_state = S_C_RD;
            end
            S_O_RD: n_state = S_O_EVAL;
            S_O_EVAL: n_state = (i_stat.gt && i_stat.rem_one) ? S_CLR_INIT : S_O_RD;
            S_CLR_INIT: n_state = S_CLR;
            S_CLR: n_state = i_stat.clr_end ? S_IDLE : S_CLR;
            default: n_state = S_CLR_INIT;
        endcase
    end

    always_comb begin
        o_cmd.accept = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.op     = OP_IDLE;
                o_cmd.accept = start;
            end
            S_E_RD1:    o_cmd.op = OP_E_RD1;
            S_E_WR1:    o_cmd.op = OP_E_WR1;
            S_E_RD2:    o_cmd.op = OP_E_RD2;
            S_E_WR2:    o_cmd.op = OP_E_WR2;
            S_P1_INIT:  o_cmd.op = OP_P1_INIT;
            S_P1_SCAN:  o_cmd.op = OP_P1_SCAN;
            S_P1_RD:    o_cmd.op = OP_P1_RD;
            S_P1_EVAL:  o_cmd.op = OP_P1_EVAL;
            S_P1_POP:   o_cmd.op = OP_P1_POP;
            S_P2_INIT:  o_cmd.op = OP_P2_INIT;
            S_P2_FRD:   o_cmd.op = OP_P2_FRD;
            S_P2_ROOT:  o_cmd.op = OP_P2_ROOT;
            S_P2_RD:    o_cmd.op = OP_P2_RD;
            S_P2_EVAL:  o_cmd.op = OP_P2_EVAL;
            S_P2_POP:   o_cmd.op = OP_P2_POP;
            S_C_INIT:   o_cmd.op = OP_C_INIT;
            S_C_RD:     o_cmd.op = OP_C_RD;
            S_C_EVAL:   o_cmd.op = OP_C_EVAL;
            S_O_RD:     o_cmd.op = OP_O_RD;
            S_O_EVAL:   o_cmd.op = OP_O_EVAL;
            S_CLR_INIT: o_cmd.op = OP_CLR_INIT;
            S_CLR:      o_cmd.op = OP_CLR;
            default:    o_cmd.op = OP_CLR_INIT;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/tss_dp.sv =====
// ----------------------------------------------------------------------------
// 2-SAT SCC solver datapath
// Forward and transposed implication matrices, search stack, visit masks,
// finish order, component numbers and the result register.
// ----------------------------------------------------------------------------
`include "two_sat_scc_solver_core_macros.svh"

module tss_dp
    import tss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [NV_W-1:0]  i_num_vars,
    input  logic [VAR_W-1:0] i_from_var,
    input  logic             i_from_negated,
    input  logic [VAR_W-1:0] i_to_var,
    input  logic             i_to_negated,
    input  logic             i_carries_edge,
    input  logic             i_last,
    output t_stat            o_stat,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [NV_W-1:0]  o_value,
    output logic             o_last_result
);

    logic [NV_W-1:0]    r_n;
    logic [LIT_W-1:0]   r_u, r_v, r_un, r_vn, r_top;
    logic               r_last;
    logic [LIT_NUM-1:0] r_vis, r_asg, r_valid;
    logic [CNT_W-1:0]   r_i, r_sp, r_fc, r_k, r_cc;
    logic [NV_W-1:0]    r_cnt, r_rem;
    logic               r_out_valid, r_out_last;
    logic [1:0]         r_out_status;
    logic [NV_W-1:0]    r_out_value;

    logic [NV_W-1:0]    n_eff;
    logic [LIT_W-1:0]   fv_ext, tv_ext;
    logic               in_edge;
    logic [CNT_W-1:0]   n2;
    logic [LIT_NUM-1:0] valid_mask, mrow;
    logic [LIT_W-1:0]   w;
    logic [NV_W-1:0]    cnt_next;

    logic               mat_we, trn_we, stk_we, fin_we, cp_we;
    logic [LIT_W-1:0]   mat_wa, mat_ra, trn_wa, trn_ra, stk_wa, stk_ra, fin_wa, fin_ra;
    logic [LIT_W-1:0]   cp_wa, cpa_ra, cpb_ra;
    logic [LIT_NUM-1:0] mat_wd, mat_rd, trn_wd, trn_rd;
    logic [LIT_W-1:0]   stk_wd, stk_rd, fin_wd, fin_rd, cp_wd, cpa_rd, cpb_rd;

    assign n_eff   = eff_vars(i_num_vars);
    assign fv_ext  = LIT_W'(i_from_var);
    assign tv_ext  = LIT_W'(i_to_var);
    assign in_edge = i_carries_edge && (fv_ext < n_eff) && (tv_ext < n_eff);
    assign n2      = {r_n, 1'b0};

    always_comb begin
        for (int j = 0; j < LIT_NUM; j++) begin
            valid_mask[j] = (CNT_W'(j) < n2);
        end
    end

    assign mrow     = ((i_cmd.op == OP_P2_EVAL) ? (trn_rd & ~r_asg) : (mat_rd & ~r_vis))
                      & r_valid;
    assign w        = low_bit(mrow);
    assign cnt_next = r_cnt + NV_W'(cpa_rd > cpb_rd);

    always_comb begin
        o_stat.in_edge   = in_edge;
        o_stat.in_last   = i_last;
        o_stat.last_item = r_last;
        o_stat.scan_end  = (r_i == n2);
        o_stat.vis_hit   = r_vis[r_i[LIT_W-1:0]];
        o_stat.m_nz      = (mrow != '0);
        o_stat.sp_one    = (r_sp == CNT_W'(1));
        o_stat.k_zero    = (r_k == '0);
        o_stat.root_done = r_asg[fin_rd];
        o_stat.eq        = (cpa_rd == cpb_rd);
        o_stat.gt        = (cpa_rd > cpb_rd);
        o_stat.var_last  = (r_i == CNT_W'(r_n) - CNT_W'(1));
        o_stat.cnt_zero  = (cnt_next == '0);
        o_stat.rem_one   = (r_rem == NV_W'(1));
        o_stat.clr_end   = (r_i == CNT_W'(LIT_NUM - 1));
    end

    always_comb begin
        mat_we = 1'b0; mat_wa = r_u;  mat_wd = '0; mat_ra = r_top;
        trn_we = 1'b0; trn_wa = r_v;  trn_wd = '0; trn_ra = r_top;
        stk_we = 1'b0; stk_wa = r_sp[LIT_W-1:0]; stk_wd = w;
        stk_ra = LIT_W'(r_sp - CNT_W'(2));
        fin_we = 1'b0; fin_wa = r_fc[LIT_W-1:0]; fin_wd = r_top;
        fin_ra = LIT_W'(r_k - CNT_W'(1));
        cp_we  = 1'b0; cp_wa = w; cp_wd = r_cc[LIT_W-1:0];
        cpa_ra = r_i[LIT_W-1:0];
        cpb_ra = LIT_W'(r_i + CNT_W'(r_n));
        case (i_cmd.op)
            OP_E_RD1: begin
                mat_ra = r_u;
                trn_ra = r_v;
            end
            OP_E_WR1: begin
                mat_we = 1'b1; mat_wa = r_u; mat_wd = mat_rd | (LIT_NUM'(1) << r_v);
                trn_we = 1'b1; trn_wa = r_v; trn_wd = trn_rd | (LIT_NUM'(1) << r_u);
            end
            OP_E_RD2: begin
                mat_ra = r_vn;
                trn_ra = r_un;
            end
            OP_E_WR2: begin
                mat_we = 1'b1; mat_wa = r_vn; mat_wd = mat_rd | (LIT_NUM'(1) << r_un);
                trn_we = 1'b1; trn_wa = r_un; trn_wd = trn_rd | (LIT_NUM'(1) << r_vn);
            end
            OP_P1_SCAN: begin
                stk_we = !o_stat.scan_end && !o_stat.vis_hit;
                stk_wa = '0;
                stk_wd = r_i[LIT_W-1:0];
            end
            OP_P1_EVAL: begin
                stk_we = o_stat.m_nz;
                fin_we = !o_stat.m_nz;
            end
            OP_P2_ROOT: begin
                stk_we = !o_stat.root_done;
                stk_wa = '0;
                stk_wd = fin_rd;
                cp_we  = !o_stat.root_done;
                cp_wa  = fin_rd;
            end
            OP_P2_EVAL: begin
                stk_we = o_stat.m_nz;
                cp_we  = o_stat.m_nz;
            end
            OP_CLR: begin
                mat_we = 1'b1; mat_wa = r_i[LIT_W-1:0];
                trn_we = 1'b1; trn_wa = r_i[LIT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis       <= '0;
            r_asg       <= '0;
            r_cc        <= '0;
            r_i         <= '0;
            r_sp        <= '0;
            r_fc        <= '0;
            r_k         <= '0;
            r_last      <= 1'b0;
            r_n         <= NV_W'(MAX_VARS);
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_IDLE: begin
                    if (i_cmd.accept) begin
                        r_n    <= n_eff;
                        r_last <= i_last;
                        r_u    <= i_from_negated ? fv_ext + n_eff : fv_ext;
                        r_un   <= i_from_negated ? fv_ext : fv_ext + n_eff;
                        r_v    <= i_to_negated ? tv_ext + n_eff : tv_ext;
                        r_vn   <= i_to_negated ? tv_ext : tv_ext + n_eff;
                    end
                end
                OP_P1_INIT: begin
                    r_i     <= '0;
                    r_fc    <= '0;
                    r_valid <= valid_mask;
                end
                OP_P1_SCAN: begin
                    if (!o_stat.scan_end) begin
                        if (o_stat.vis_hit) begin
                            r_i <= r_i + CNT_W'(1);
                        end else begin
                            r_vis[r_i[LIT_W-1:0]] <= 1'b1;
                            r_sp  <= CNT_W'(1);
                            r_top <= r_i[LIT_W-1:0];
                        end
                    end
                end
                OP_P1_EVAL: begin
                    if (o_stat.m_nz) begin
                        r_vis[w] <= 1'b1;
                        r_sp     <= r_sp + CNT_W'(1);
                        r_top    <= w;
                    end else begin
                        r_fc <= r_fc + CNT_W'(1);
                        r_sp <= r_sp - CNT_W'(1);
                        if (o_stat.sp_one) begin
                            r_i <= r_i + CNT_W'(1);
                        end
                    end
                end
                OP_P1_POP, OP_P2_POP: begin
                    r_top <= stk_rd;
                end
                OP_P2_INIT: begin
                    r_k <= r_fc;
                end
                OP_P2_ROOT: begin
                    if (o_stat.root_done) begin
                        r_k <= r_k - CNT_W'(1);
                    end else begin
                        r_asg[fin_rd] <= 1'b1;
                        r_sp  <= CNT_W'(1);
                        r_top <= fin_rd;
                    end
                end
                OP_P2_EVAL: begin
                    if (o_stat.m_nz) begin
                        r_asg[w] <= 1'b1;
                        r_sp     <= r_sp + CNT_W'(1);
                        r_top    <= w;
                    end else begin
                        r_sp <= r_sp - CNT_W'(1);
                        if (o_stat.sp_one) begin
                            r_cc <= r_cc + CNT_W'(1);
                            r_k  <= r_k - CNT_W'(1);
                        end
                    end
                end
                OP_C_INIT: begin
                    r_i   <= '0;
                    r_cnt <= '0;
                end
                OP_C_EVAL: begin
                    if (o_stat.eq) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_UNSAT;
                        r_out_value  <= '0;
                        r_out_last   <= 1'b1;
                    end else if (o_stat.var_last) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_COUNT;
                        r_out_value  <= cnt_next;
                        r_out_last   <= o_stat.cnt_zero;
                        r_rem        <= cnt_next;
                        r_i          <= '0;
                    end else begin
                        r_cnt <= cnt_next;
                        r_i   <= r_i + CNT_W'(1);
                    end
                end
                OP_O_EVAL: begin
                    if (o_stat.gt) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_TRUE;
                        r_out_value  <= NV_W'(r_i);
                        r_out_last   <= o_stat.rem_one;
                        r_rem        <= r_rem - NV_W'(1);
                    end
                    r_i <= r_i + CNT_W'(1);
                end
                OP_CLR_INIT: begin
                    r_i   <= '0;
                    r_vis <= '0;
                    r_asg <= '0;
                    r_cc  <= '0;
                end
                OP_CLR: begin
                    r_i <= r_i + CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    tss_ram #(.WIDTH(LIT_NUM), .DEPTH(LIT_NUM)) u_mat (
        .i_clk(i_clk), .i_we(mat_we), .i_waddr(mat_wa), .i_wdata(mat_wd),
        .i_raddr(mat_ra), .o_rdata(mat_rd)
    );
    tss_ram #(.WIDTH(LIT_NUM), .DEPTH(LIT_NUM)) u_trn (
        .i_clk(i_clk), .i_we(trn_we), .i_waddr(trn_wa), .i_wdata(trn_wd),
        .i_raddr(trn_ra), .o_rdata(trn_rd)
    );
    tss_ram #(.WIDTH(LIT_W), .DEPTH(LIT_NUM)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd)
    );
    tss_ram #(.WIDTH(LIT_W), .DEPTH(LIT_NUM)) u_fin (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_wa), .i_wdata(fin_wd),
        .i_raddr(fin_ra), .o_rdata(fin_rd)
    );
    tss_ram #(.WIDTH(LIT_W), .DEPTH(LIT_NUM)) u_cpa (
        .i_clk(i_clk), .i_we(cp_we), .i_waddr(cp_wa), .i_wdata(cp_wd),
        .i_raddr(cpa_ra), .o_rdata(cpa_rd)
    );
    tss_ram #(.WIDTH(LIT_W), .DEPTH(LIT_NUM)) u_cpb (
        .i_clk(i_clk), .i_we(cp_we), .i_waddr(cp_wa), .i_wdata(cp_wd),
        .i_raddr(cpb_ra), .o_rdata(cpb_rd)
    );

    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_value        = r_out_value;
    assign o_last_result  = r_out_last;

    // results never come back to back
    `TSS_ASSERT_NEXT(a_result_gap, r_out_valid, !r_out_valid, "back-to-back results")
    `TSS_ASSERT(a_sp_bound, r_sp <= CNT_W'(LIT_NUM), "stack overflow")
    `TSS_ASSERT(a_fc_bound, r_fc <= CNT_W'(LIT_NUM), "finish order overflow")
    `TSS_ASSERT_NEXT(a_unsat_last, r_out_valid && (r_out_status == ST_UNSAT),
                     r_vis == '0 || r_i == CNT_W'(1), "unsat not followed by clear")

endmodule

// ===== rtl/two_sat_scc_solver_core.sv =====
// ----------------------------------------------------------------------------
// 2-SAT SCC solver core
// Loads literal implications into a bit matrix and solves 2-SAT by two
// depth-first passes (strongly connected components), then reports results.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         start / busy              i_from_var .. i_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (num_vars)
// result    out        o_result_valid (1 cycle)  o_status, o_value, o_last_result
//
// An edge item runs two read-modify-write passes over the matrix and transpose
// RAMs before the core is idle again; an item without an edge is taken from idle.
// The solve runs both search passes, the component compare and, if any variable
// is true, the output scan, then a full matrix clear.
// After reset the same matrix clear runs with busy high.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module two_sat_scc_solver_core
    import tss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [VAR_W-1:0] i_from_var,
    input  logic             i_from_negated,
    input  logic [VAR_W-1:0] i_to_var,
    input  logic             i_to_negated,
    input  logic             i_carries_edge,
    input  logic             i_last,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [NV_W-1:0]  i_cfg_data,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [NV_W-1:0]  o_value,
    output logic             o_last_result
);

    logic [NV_W-1:0] r_num_vars;
    t_cmd            cmd;
    t_stat           stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= NV_W'(MAX_VARS);
        end else if (i_cfg_valid) begin
            r_num_vars <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    tss_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .busy   (busy)
    );

    tss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_num_vars    (r_num_vars),
        .i_from_var    (i_from_var),
        .i_from_negated(i_from_negated),
        .i_to_var      (i_to_var),
        .i_to_negated  (i_to_negated),
        .i_carries_edge(i_carries_edge),
        .i_last        (i_last),
        .o_stat        (stat),
        .o_result_valid(o_result_valid),
        .o_status      (o_status),
        .o_value       (o_value),
        .o_last_result (o_last_result)
    );

endmodule
